// ----- design/rpg_pkg.sv -----
package rpg_pkg;

    localparam int VAL_W      = 16;
    localparam int OFF_W      = 24;
    localparam int XRES_W     = 12;
    localparam int YRES_W     = 12;
    localparam int STRIDE_W   = 13;
    localparam int BOUND_W    = XRES_W + YRES_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_X_RES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd2;

    localparam logic [XRES_W-1:0]   X_RES_RST  = 12'd640;
    localparam logic [YRES_W-1:0]   Y_RES_RST  = 12'd480;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd640;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef struct packed {
        logic pix;
        logic last;
        logic idle;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

// ----- design/rpg_if.sv -----
interface rpg_in_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] corner_x;
    logic signed [COORD_BITS-1:0] corner_y;
    logic signed [COORD_BITS-1:0] rect_width;
    logic signed [COORD_BITS-1:0] rect_height;
    logic [15:0]                  fill_colour;
    logic                         filled;

    modport source (
        output valid, func, corner_x, corner_y, rect_width, rect_height, fill_colour, filled,
        input  ready
    );
    modport sink (
        input  valid, func, corner_x, corner_y, rect_width, rect_height, fill_colour, filled,
        output ready
    );
endinterface

interface rpg_out_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [23:0] pixel_offset;
    logic [15:0] pixel_value;
    logic        last_pixel;
    logic        idle;

    modport source (
        output valid, write_enable, pixel_offset, pixel_value, last_pixel, idle,
        input  ready
    );
    modport sink (
        input  valid, write_enable, pixel_offset, pixel_value, last_pixel, idle,
        output ready
    );
endinterface

// ----- design/rpg_front.sv -----
module rpg_front
    import rpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rpg_in_if.sink                         i_cmd,
    input  logic                           i_full,
    output logic                           o_push,
    output t_flags                         o_flags,
    output logic [VAL_W-1:0]               o_colour,
    output logic signed [COORD_BITS+1:0]   o_x,
    output logic signed [COORD_BITS+1:0]   o_y
);

    localparam int CW = COORD_BITS;
    localparam int XW = COORD_BITS + 2;

    typedef enum logic [3:0] {
        EDGE_TOP    = 4'b0001,
        EDGE_LEFT   = 4'b0010,
        EDGE_RIGHT  = 4'b0100,
        EDGE_BOTTOM = 4'b1000
    } t_edge;

    logic                 r_active, n_active;
    logic signed [CW-1:0] r_ox, n_ox;
    logic signed [CW-1:0] r_oy, n_oy;
    logic signed [CW-1:0] r_w, n_w;
    logic signed [CW-1:0] r_h, n_h;
    logic [VAL_W-1:0]     r_colour, n_colour;
    logic                 r_filled, n_filled;
    t_edge                r_edge, n_edge;
    logic [CW-1:0]        r_outer, n_outer;
    logic [CW-1:0]        r_inner, n_inner;

    logic signed [XW-1:0] ox_e, oy_e, w_e, h_e, ic_e, oc_e, inner_len;
    logic                 inner_end, outer_end, load_nonempty;

    assign ox_e = XW'(r_ox);
    assign oy_e = XW'(r_oy);
    assign w_e  = XW'(r_w);
    assign h_e  = XW'(r_h);
    assign ic_e = $signed({2'b00, r_inner});
    assign oc_e = $signed({2'b00, r_outer});

    assign inner_len = (r_filled || r_edge == EDGE_LEFT || r_edge == EDGE_RIGHT) ? h_e : w_e;
    assign inner_end = ic_e >= inner_len - XW'(1);
    assign outer_end = r_filled ? (oc_e >= w_e - XW'(1)) : (r_edge == EDGE_BOTTOM);
    assign load_nonempty = (i_cmd.rect_width > 0) && (i_cmd.rect_height > 0);

    assign i_cmd.ready = !i_full;
    assign o_push      = i_cmd.valid && !i_full;

    always_comb begin
        o_x = ox_e + ic_e;
        o_y = oy_e;
        if (r_filled) begin
            o_x = ox_e + oc_e;
            o_y = oy_e + ic_e;
        end else begin
            case (r_edge)
                EDGE_TOP: begin
                    o_x = ox_e + ic_e;
                    o_y = oy_e;
                end
                EDGE_LEFT: begin
                    o_x = ox_e;
                    o_y = oy_e + ic_e;
                end
                EDGE_RIGHT: begin
                    o_x = ox_e + w_e - XW'(1);
                    o_y = oy_e + ic_e;
                end
                default: begin
                    o_x = ox_e + ic_e;
                    o_y = oy_e + h_e - XW'(1);
                end
            endcase
        end
    end

    always_comb begin
        n_active = r_active;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_w      = r_w;
        n_h      = r_h;
        n_colour = r_colour;
        n_filled = r_filled;
        n_edge   = r_edge;
        n_outer  = r_outer;
        n_inner  = r_inner;
        o_flags  = '{pix: 1'b0, last: 1'b0, idle: !r_active};
        o_colour = r_colour;
        if (i_cmd.func == FUNC_LOAD) begin
            n_ox     = i_cmd.corner_x;
            n_oy     = i_cmd.corner_y;
            n_w      = i_cmd.rect_width;
            n_h      = i_cmd.rect_height;
            n_colour = i_cmd.fill_colour;
            n_filled = i_cmd.filled;
            n_edge   = EDGE_TOP;
            n_outer  = '0;
            n_inner  = '0;
            n_active = load_nonempty;
            o_flags  = '{pix: 1'b0, last: 1'b0, idle: !load_nonempty};
        end else if (r_active) begin
            if (inner_end) begin
                n_inner = '0;
                if (outer_end) begin
                    n_active = 1'b0;
                end else if (r_filled) begin
                    n_outer = r_outer + CW'(1);
                end else begin
                    case (r_edge)
                        EDGE_TOP:   n_edge = EDGE_LEFT;
                        EDGE_LEFT:  n_edge = EDGE_RIGHT;
                        default:    n_edge = EDGE_BOTTOM;
                    endcase
                end
            end else begin
                n_inner = r_inner + CW'(1);
            end
            o_flags = '{pix: 1'b1, last: inner_end && outer_end, idle: inner_end && outer_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_w      <= '0;
            r_h      <= '0;
            r_colour <= '0;
            r_filled <= 1'b0;
            r_edge   <= EDGE_TOP;
            r_outer  <= '0;
            r_inner  <= '0;
        end else if (o_push) begin
            r_active <= n_active;
            r_ox     <= n_ox;
            r_oy     <= n_oy;
            r_w      <= n_w;
            r_h      <= n_h;
            r_colour <= n_colour;
            r_filled <= n_filled;
            r_edge   <= n_edge;
            r_outer  <= n_outer;
            r_inner  <= n_inner;
        end
    end

    a_last_clears_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_flags.last |=> !r_active)
        else $error("active still set after last pixel");

    a_active_span_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_w > 0) && (r_h > 0))
        else $error("active with empty rectangle");

endmodule

// ----- design/rpg_queue.sv -----
module rpg_queue #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CNTW-1:0]  r_count, n_count;

    assign o_full  = r_count == CNTW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// ----- design/rpg_back.sv -----
module rpg_back
    import rpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_pop,
    input  t_flags                       i_flags,
    input  logic [VAL_W-1:0]             i_colour,
    input  logic signed [COORD_BITS+1:0] i_x,
    input  logic signed [COORD_BITS+1:0] i_y,
    rpg_out_if.source                    o_pix
);

    localparam int XW = COORD_BITS + 2;
    localparam int PW = XW + STRIDE_W + 1;
    localparam int SW = PW + 1;

    logic [XRES_W-1:0]    r_xres;
    logic [YRES_W-1:0]    r_yres;
    logic [STRIDE_W-1:0]  r_stride;
    logic [BOUND_W-1:0]   r_bound;

    logic                 adv;
    logic                 r_a_valid;
    t_flags               r_a_flags;
    logic [VAL_W-1:0]     r_a_colour;
    logic signed [XW-1:0] r_a_x;
    logic signed [PW-1:0] r_a_prod, n_a_prod;

    logic                 r_out_valid;
    logic                 r_we;
    logic [OFF_W-1:0]     r_off;
    logic [VAL_W-1:0]     r_val;
    logic                 r_last;
    logic                 r_idle;

    logic signed [SW-1:0] sum, bound_e;
    logic                 in_bounds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xres   <= X_RES_RST;
            r_yres   <= Y_RES_RST;
            r_stride <= STRIDE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_RES:  r_xres   <= i_cfg_data[XRES_W-1:0];
                CFG_Y_RES:  r_yres   <= i_cfg_data[YRES_W-1:0];
                CFG_STRIDE: r_stride <= i_cfg_data[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_bound <= BOUND_W'(r_xres) * BOUND_W'(r_yres);
    end

    assign adv   = !r_out_valid || o_pix.ready;
    assign o_pop = adv && i_valid;

    assign n_a_prod = PW'(i_y) * PW'($signed({1'b0, r_stride}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_flags  <= i_flags;
            r_a_colour <= i_colour;
            r_a_x      <= i_x;
            r_a_prod   <= n_a_prod;
        end
    end

    assign sum       = SW'(r_a_prod) + SW'(r_a_x);
    assign bound_e   = $signed(SW'(r_bound));
    assign in_bounds = !sum[SW-1] && (sum < bound_e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_we   <= r_a_flags.pix && in_bounds;
            r_off  <= (r_a_flags.pix && in_bounds) ? sum[OFF_W-1:0] : '0;
            r_val  <= r_a_flags.pix ? r_a_colour : '0;
            r_last <= r_a_flags.last;
            r_idle <= r_a_flags.idle;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.write_enable = r_we;
    assign o_pix.pixel_offset = r_off;
    assign o_pix.pixel_value  = r_val;
    assign o_pix.last_pixel   = r_last;
    assign o_pix.idle         = r_idle;

    a_off_zero_when_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_we |-> r_off == '0)
        else $error("offset set on a disabled write");

    a_last_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_last |-> r_idle)
        else $error("last pixel without idle");

endmodule

// ----- design/rectangle_pixel_generator.sv -----
// Rectangle pixel generator.
// i_cmd carries command transfers: func LOAD latches a rectangle (corner, size,
// colour, filled/outline); func STEP produces the next pixel of that shape.
// Every command transfer yields exactly one transfer on o_pix: write_enable,
// pixel_offset (y * stride + x), pixel_value, last_pixel and idle.
// Configuration (x resolution, y resolution, line stride) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while no
// command is in flight, as the block itself does not enforce this.
// Throughput: one command per cycle, sustained while o_pix is not stalled. Each
// result goes via the queue slot, stride multiply and add/bounds stages to o_pix.
// A queue of QUEUE_DEPTH entries sits between command decode and the pixel
// address pipeline; when o_pix is stalled the pipeline holds and the queue
// fills, and i_cmd.ready drops only once the queue is full.
// Reset (synchronous, active low) clears the rectangle, empties the queue
// and pipeline, and restores 640 x 480 with a stride of 640.
module rectangle_pixel_generator
    import rpg_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rpg_in_if.sink                i_cmd,
    rpg_out_if.source             o_pix
);

    localparam int XW = COORD_BITS + 2;
    localparam int QW = FLAGS_W + VAL_W + 2 * XW;

    logic                 push, full, pop, q_valid;
    t_flags               f_flags, q_flags;
    logic [VAL_W-1:0]     f_colour, q_colour;
    logic signed [XW-1:0] f_x, f_y, q_x, q_y;
    logic [QW-1:0]        q_in, q_out;

    rpg_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_full   (full),
        .o_push   (push),
        .o_flags  (f_flags),
        .o_colour (f_colour),
        .o_x      (f_x),
        .o_y      (f_y)
    );

    assign q_in = {f_flags, f_colour, f_x, f_y};

    rpg_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {q_flags, q_colour, q_x, q_y} = q_out;

    rpg_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (q_valid),
        .o_pop      (pop),
        .i_flags    (q_flags),
        .i_colour   (q_colour),
        .i_x        (q_x),
        .i_y        (q_y),
        .o_pix      (o_pix)
    );

endmodule

// ----- bench/rect_pixel_check.sv -----
module rect_pixel_check
    import rpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rpg_in_if                     i_cmd,
    rpg_out_if                    i_pix,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_written,
    output int                    o_shapes
);

    typedef struct packed {
        logic             we;
        logic [OFF_W-1:0] off;
        logic [VAL_W-1:0] val;
        logic             last;
        logic             idle;
    } t_pix;

    typedef enum logic [1:0] {SIDE_TOP, SIDE_LEFT, SIDE_RIGHT, SIDE_BOTTOM} t_side;

    t_pix expected_pix[$];

    logic [XRES_W-1:0]     x_res;
    logic [YRES_W-1:0]     y_res;
    logic [STRIDE_W-1:0]   stride;
    logic                  active;
    logic                  mode_fill;
    logic [COORD_BITS-1:0] org_x, org_y, span_w, span_h;
    logic [VAL_W-1:0]      colour_held;
    t_side                 side;
    logic [COORD_BITS-1:0] col_cnt, pos_cnt;

    int errs    = 0;
    int written = 0;
    int shapes  = 0;

    function automatic t_pix next_pixel(
        input logic                  func,
        input logic [COORD_BITS-1:0] cx,
        input logic [COORD_BITS-1:0] cy,
        input logic [COORD_BITS-1:0] w,
        input logic [COORD_BITS-1:0] h,
        input logic [VAL_W-1:0]      colour,
        input logic                  fill
    );
        t_pix   r;
        longint ox, oy, sw, sh, ic, oc, x, y, len, offs, bound;
        r = '0;
        if (func == FUNC_LOAD) begin
            org_x       = cx;
            org_y       = cy;
            span_w      = w;
            span_h      = h;
            colour_held = colour;
            mode_fill   = fill;
            side        = SIDE_TOP;
            col_cnt     = '0;
            pos_cnt     = '0;
            active      = ($signed(w) > 0) && ($signed(h) > 0);
        end else if (active) begin
            ox = longint'($signed(org_x));
            oy = longint'($signed(org_y));
            sw = longint'($signed(span_w));
            sh = longint'($signed(span_h));
            ic = longint'(pos_cnt);
            oc = longint'(col_cnt);
            if (mode_fill) begin
                x = ox + oc;
                y = oy + ic;
                if (ic >= sh - 1) begin
                    pos_cnt = '0;
                    if (oc >= sw - 1) begin
                        r.last = 1'b1;
                        active = 1'b0;
                    end else begin
                        col_cnt = col_cnt + COORD_BITS'(1);
                    end
                end else begin
                    pos_cnt = pos_cnt + COORD_BITS'(1);
                end
            end else begin
                len = (side == SIDE_LEFT || side == SIDE_RIGHT) ? sh : sw;
                case (side)
                    SIDE_TOP: begin
                        x = ox + ic;
                        y = oy;
                    end
                    SIDE_LEFT: begin
                        x = ox;
                        y = oy + ic;
                    end
                    SIDE_RIGHT: begin
                        x = ox + sw - 1;
                        y = oy + ic;
                    end
                    default: begin
                        x = ox + ic;
                        y = oy + sh - 1;
                    end
                endcase
                if (ic >= len - 1) begin
                    pos_cnt = '0;
                    if (side == SIDE_BOTTOM) begin
                        r.last = 1'b1;
                        active = 1'b0;
                    end else begin
                        side = t_side'(side + 2'd1);
                    end
                end else begin
                    pos_cnt = pos_cnt + COORD_BITS'(1);
                end
            end
            offs  = y * longint'(stride) + x;
            bound = longint'(x_res) * longint'(y_res);
            if (offs >= 0 && offs < bound) begin
                r.we  = 1'b1;
                r.off = offs[OFF_W-1:0];
            end
            r.val = colour_held;
        end
        r.idle = !active;
        return r;
    endfunction

    task automatic check_field(input string field, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            errs++;
            $display("%0t %s: expected %0h, got %0h", $time, field, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_pix got;
        t_pix want;
        if (!i_rst_n) begin
            x_res       = X_RES_RST;
            y_res       = Y_RES_RST;
            stride      = STRIDE_RST;
            active      = 1'b0;
            mode_fill   = 1'b0;
            org_x       = '0;
            org_y       = '0;
            span_w      = '0;
            span_h      = '0;
            colour_held = '0;
            side        = SIDE_TOP;
            col_cnt     = '0;
            pos_cnt     = '0;
            expected_pix.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_RES:  x_res  = i_cfg_data[XRES_W-1:0];
                    CFG_Y_RES:  y_res  = i_cfg_data[YRES_W-1:0];
                    CFG_STRIDE: stride = i_cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                got = {i_pix.write_enable, i_pix.pixel_offset, i_pix.pixel_value,
                       i_pix.last_pixel, i_pix.idle};
                if (expected_pix.size() == 0) begin
                    errs++;
                    $display("%0t unexpected pixel transfer: expected none, got %0h",
                             $time, got);
                end else begin
                    want = expected_pix.pop_front();
                    check_field("write_enable", longint'(want.we), longint'(got.we));
                    check_field("pixel_offset", longint'(want.off), longint'(got.off));
                    check_field("pixel_value", longint'(want.val), longint'(got.val));
                    check_field("last_pixel", longint'(want.last), longint'(got.last));
                    check_field("idle", longint'(want.idle), longint'(got.idle));
                    if (got.we) written++;
                    if (got.last) shapes++;
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                expected_pix.push_back(next_pixel(i_cmd.func, i_cmd.corner_x, i_cmd.corner_y,
                                                  i_cmd.rect_width, i_cmd.rect_height,
                                                  i_cmd.fill_colour, i_cmd.filled));
            end
        end
        o_errors  <= errs;
        o_pending <= expected_pix.size();
        o_written <= written;
        o_shapes  <= shapes;
    end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    import rpg_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int PHASE_ITEMS = 260;
    localparam int IDLE_LIMIT  = 200;
    localparam int N_PHASES    = 7;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_X_RES;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    rpg_in_if #(.COORD_BITS(COORD_BITS)) cmd_if ();
    rpg_out_if                           pix_if ();

    int errors, pending, written, shapes;
    int n_items    = 0;
    int cur_x      = 640;
    int cur_y      = 480;
    int idle_count = 0;
    bit calm       = 1'b0;
    int stall_left = 0;

    rectangle_pixel_generator #(.COORD_BITS(COORD_BITS)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_pix      (pix_if)
    );

    rect_pixel_check #(.COORD_BITS(COORD_BITS)) pix_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .i_pix      (pix_if),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_written  (written),
        .o_shapes   (shapes)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pixel sink: random stall after each transfer
    always @(posedge i_clk) begin
        int stall_draw;
        if (!i_rst_n) begin
            pix_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (pix_if.valid && pix_if.ready) begin
            stall_draw = calm ? 0 : $urandom_range(0, 4);
            stall_left   <= stall_draw;
            pix_if.ready <= (stall_draw == 0);
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            pix_if.ready <= (stall_left == 1);
        end else begin
            pix_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("rectangle_pixel_generator test failed");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    task automatic send(input logic f, input logic [11:0] cx, input logic [11:0] cy,
                        input logic [11:0] w, input logic [11:0] h,
                        input logic [15:0] colour, input logic fill);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.func        <= f;
        cmd_if.corner_x    <= cx;
        cmd_if.corner_y    <= cy;
        cmd_if.rect_width  <= w;
        cmd_if.rect_height <= h;
        cmd_if.fill_colour <= colour;
        cmd_if.filled      <= fill;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        n_items++;
    endtask

    task automatic load(input logic [11:0] cx, input logic [11:0] cy, input logic [11:0] w,
                        input logic [11:0] h, input logic [15:0] colour, input logic fill);
        send(FUNC_LOAD, cx, cy, w, h, colour, fill);
    endtask

    task automatic step(input int n);
        repeat (n) send(FUNC_STEP, 12'($urandom), 12'($urandom), 12'($urandom),
                        12'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_settings(input int x, input int y, input int s);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_X_RES;
        i_cfg_data <= CFG_DATA_W'(x);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_Y_RES;
        i_cfg_data <= CFG_DATA_W'(y);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STRIDE;
        i_cfg_data <= CFG_DATA_W'(s);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_x = x & 12'hFFF;
        cur_y = y & 12'hFFF;
    endtask

    // corner near the origin, near the far edge of the screen, or anywhere
    function automatic logic [11:0] pick_coord(input int lim);
        case ($urandom_range(0, 2))
            0:       return 12'(int'($urandom_range(0, 16)) - 6);
            1:       return 12'(lim - int'($urandom_range(0, 8)));
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic rect_sequence();
        logic [11:0] cx, cy, w, h;
        logic        fill;
        int          kind, len, steps;
        kind = $urandom_range(0, 99);
        fill = 1'($urandom_range(0, 1));
        cx   = pick_coord(cur_x);
        cy   = pick_coord(cur_y);
        calm = ($urandom_range(0, 5) == 0);
        if (kind < 85) begin
            if ($urandom_range(0, 29) == 0) begin
                w = 12'($urandom_range(7, 24));
                h = 12'($urandom_range(7, 24));
            end else begin
                w = 12'($urandom_range(1, 6));
                h = 12'($urandom_range(1, 6));
            end
            len = fill ? int'(w) * int'(h) : 2 * (int'(w) + int'(h));
            if (kind < 70)
                steps = len + $urandom_range(0, 2);
            else
                steps = $urandom_range(0, len - 1);
        end else if (kind < 95) begin
            w     = 12'($urandom);
            h     = 12'($urandom);
            steps = $urandom_range(0, 6);
        end else begin
            w = 12'($urandom);
            h = 12'($urandom);
            if ($urandom_range(0, 1)) w = '0;
            else h[11] = 1'b1;
            steps = $urandom_range(0, 3);
        end
        load(cx, cy, w, h, 16'($urandom), fill);
        step(steps);
    endtask

    initial begin
        int px[N_PHASES];
        int py[N_PHASES];
        int ps[N_PHASES];
        int target;
        px = '{640, 4095, 1, 16, 0, 0, 100};
        py = '{480, 4095, 1, 12, 7, 0, 60};
        ps = '{640, 4096, 1, 16, 0, 0, 128};
        px[5] = $urandom_range(1, 4095);
        py[5] = $urandom_range(1, 4095);
        ps[5] = $urandom_range(1, 4096);

        cmd_if.valid       = 1'b0;
        cmd_if.func        = FUNC_LOAD;
        cmd_if.corner_x    = '0;
        cmd_if.corner_y    = '0;
        cmd_if.rect_width  = '0;
        cmd_if.rect_height = '0;
        cmd_if.fill_colour = '0;
        cmd_if.filled      = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle step, empty shapes, pixel zero, last visible pixel,
        // far corner, abandon while busy
        step(1);
        load(12'd0, 12'd0, 12'd0, 12'd5, 16'h1234, 1'b1);
        step(1);
        load(12'd5, 12'd5, 12'h800, 12'd2047, 16'h4321, 1'b0);
        load(12'd0, 12'd0, 12'd2, 12'd2, 16'hFFFF, 1'b1);
        step(5);
        load(12'd639, 12'd479, 12'd1, 12'd1, 16'h0000, 1'b0);
        step(4);
        load(12'd2047, 12'd2047, 12'd2047, 12'd2047, 16'hA5A5, 1'b1);
        step(1);
        load(12'h800, 12'h800, 12'd3, 12'd1, 16'h5A5A, 1'b0);
        step(2);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p != 0) write_settings(px[p], py[p], ps[p]);
            target = n_items + PHASE_ITEMS;
            while (n_items < target) rect_sequence();
        end

        calm = 1'b0;
        drain();
        repeat (6) @(posedge i_clk);

        $display("%0d commands over %0d register settings, incl. max, min and zero sizes",
                 n_items, N_PHASES);
        $display("%0d pixel writes enabled, %0d shapes drawn to the end", written, shapes);
        if (errors == 0)
            $display("rectangle_pixel_generator test passed");
        else
            $display("rectangle_pixel_generator test failed");
        $finish;
    end

endmodule
